@@ hw/rtl/slt_pkg.sv @@
// Shared types and constants for the sorted list table.
package slt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int HIT_W    = 8;
    localparam int ECNT_W   = 9;
    // width wide enough to compare a cell index against the request position
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [OP_W-1:0]         op_t;
    typedef logic [STAT_W-1:0]       stat_t;

    localparam op_t OP_SEARCH = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_DELETE = 2'd2;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_FULL  = 2'd1;
    localparam stat_t STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } fsm_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic  cmp;    // latch compare flags
        logic  ins;    // commit an insert
        logic  del;    // commit a delete
        key_t  key;
        pos_t  pos;
        cnt_t  count;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/slt_cell.sv @@
// One table slot: holds a key, compares it and shifts with its neighbors.
module slt_cell (
    input  logic               aclk,
    input  slt_pkg::cell_ctrl_t ctrl,
    input  slt_pkg::idx_t      cell_idx,
    input  slt_pkg::key_t      left_entry,
    input  logic               left_gt,
    input  logic               left_eq,
    input  slt_pkg::key_t      right_entry,
    output slt_pkg::key_t      entry,
    output logic               gt,
    output logic               eq,
    output logic               first
);
    import slt_pkg::*;

    key_t entry_reg;
    logic gt_reg;
    logic eq_reg;
    cnt_t my_idx;
    logic valid;
    logic take_new;
    logic shift_down;

    assign my_idx     = {1'b0, cell_idx};
    assign valid      = my_idx < ctrl.count;
    // insert: slots holding larger keys move up, plus the slot just past the end
    assign take_new   = (valid && gt_reg) || (my_idx == ctrl.count);
    // delete: slots from the position up to the next-to-last pull from above
    assign shift_down = valid && (CMP_W'(my_idx) >= CMP_W'(ctrl.pos))
                        && ((my_idx + cnt_t'(1)) < ctrl.count);

    always_ff @(posedge aclk) begin
        if (ctrl.cmp) begin
            gt_reg <= valid && (entry_reg > ctrl.key);
            eq_reg <= valid && (entry_reg == ctrl.key);
        end
        if (ctrl.ins && take_new) begin
            entry_reg <= left_gt ? left_entry : ctrl.key;
        end else if (ctrl.del && shift_down) begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;
    // sorted table: the first match is the one whose lower neighbor differs
    assign first = eq_reg && !left_eq;

endmodule

@@ hw/rtl/sorted_list_table.sv @@
// Top level of the sorted list table: sequencer, result register and cell chain.
//
//  channel  | dir | tdata fields (lsb first)                         | width
//  s_axis   | in  | opcode[1:0] key[33:2] position[41:34] pad        | 48
//  m_axis   | out | found[0] hit_index[8:1] entry_count[17:9]        | 24
//           |     | status[19:18] pad                                |
//
// Each transaction runs through three steps: accept, compare, apply. The compare
// flags of every cell are registered in a stage of their own before the shift.
// One transaction is in work at a time; s_tready is high while the sequencer
// is idle, also when a result still waits on m_axis.
// The apply step holds while the result register is full and not taken.
// Reset (aresetn low, synchronous) clears the count and the handshake state;
// the key slots are left as they are and only slots below the count are read.
module sorted_list_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, key, position, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // found, hit_index, entry_count, status, zero pad
);
    import slt_pkg::*;

    fsm_t  state_reg;
    fsm_t  state_next;
    op_t   op_reg;
    key_t  key_reg;
    pos_t  pos_reg;
    cnt_t  count_reg;
    cnt_t  count_next;
    stat_t status_next;

    logic  m_tvalid_reg;
    logic  found_reg;
    idx_t  hit_reg;
    cnt_t  ecnt_reg;
    stat_t status_reg;

    logic  s_fire;
    logic  out_free;
    logic  apply_go;
    logic  can_ins;
    logic  can_del;
    logic  any_hit;
    idx_t  hit_idx;

    cell_ctrl_t ctrl;

    key_t entry_w [CAPACITY];
    logic gt_w    [CAPACITY];
    logic eq_w    [CAPACITY];
    logic first_w [CAPACITY];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign apply_go = (state_reg == ST_APPLY) && out_free;
    assign can_ins  = (op_reg == OP_INSERT) && (count_reg < cnt_t'(CAPACITY));
    assign can_del  = (op_reg == OP_DELETE) && (CMP_W'(pos_reg) < CMP_W'(count_reg));

    // broadcast to the chain
    always_comb begin
        ctrl.cmp   = (state_reg == ST_CMP);
        ctrl.ins   = apply_go && can_ins;
        ctrl.del   = apply_go && can_del;
        ctrl.key   = key_reg;
        ctrl.pos   = pos_reg;
        ctrl.count = count_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        priority if (op_reg == OP_INSERT) begin
            if (can_ins) count_next = count_reg + cnt_t'(1);
            else         status_next = STAT_FULL;
        end else if (op_reg == OP_DELETE) begin
            if (can_del) count_next = count_reg - cnt_t'(1);
            else         status_next = STAT_RANGE;
        end else begin
            count_next = count_reg;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
            pos_reg <= s_tdata[41:34];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (apply_go) begin
            count_reg <= count_next;
        end
    end

    // at most one cell flags a first match; OR the flagged indexes together
    always_comb begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_w[i]) begin
                hit_idx = hit_idx | idx_t'(i);
                any_hit = 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            found_reg  <= (op_reg == OP_SEARCH) && any_hit;
            hit_reg    <= (op_reg == OP_SEARCH) ? hit_idx : idx_t'(0);
            ecnt_reg   <= count_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, status_reg, ECNT_W'(ecnt_reg), HIT_W'(hit_reg), found_reg};

    // cell chain: cell 0 is the smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        key_t left_entry;
        logic left_gt;
        logic left_eq;
        key_t right_entry;

        if (g == 0) begin : g_lo
            assign left_entry = '0;
            assign left_gt    = 1'b0;
            assign left_eq    = 1'b0;
        end else begin : g_mid
            assign left_entry = entry_w[g-1];
            assign left_gt    = gt_w[g-1];
            assign left_eq    = eq_w[g-1];
        end

        if (g == CAPACITY - 1) begin : g_hi
            assign right_entry = '0;
        end else begin : g_up
            assign right_entry = entry_w[g+1];
        end

        slt_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_idx    (idx_t'(g)),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .left_eq     (left_eq),
            .right_entry (right_entry),
            .entry       (entry_w[g]),
            .gt          (gt_w[g]),
            .eq          (eq_w[g]),
            .first       (first_w[g])
        );
    end

endmodule
